[rtl/ornf_pkg.sv]
`default_nettype none
package ornf_pkg;

	localparam int FW_BITS = 11;
	localparam int FH_BITS = 13;
	localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
	localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_LOW    = 2'd2;
	localparam logic [1:0] CFG_HIGH   = 2'd3;

	localparam logic [3:0] TAP_CENTER = 4'd0;
	localparam logic [3:0] TAP_UL     = 4'd1;
	localparam logic [3:0] TAP_U      = 4'd2;
	localparam logic [3:0] TAP_UR     = 4'd3;
	localparam logic [3:0] TAP_L      = 4'd4;
	localparam logic [3:0] TAP_R      = 4'd5;
	localparam logic [3:0] TAP_DL     = 4'd6;
	localparam logic [3:0] TAP_D      = 4'd7;
	localparam logic [3:0] TAP_DR     = 4'd8;
	localparam logic [3:0] TAP_END    = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DECIDE,
		ST_DIV,
		ST_OUT,
		ST_WPIX
	} st_t;

endpackage
`default_nettype wire

[rtl/ornf_stream_if.sv]
`default_nettype none
interface ornf_in_if #(parameter int SAMPLE_BITS = 32);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [SAMPLE_BITS-1:0] pixel_value;

	modport source (output valid, output req_type, output pixel_value, input ready);
	modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

interface ornf_out_if #(parameter int SAMPLE_BITS = 32);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pixel_out;
	logic                          was_replaced;
	logic                          last_of_frame;

	modport source (output valid, output pixel_out, output was_replaced, output last_of_frame,
		input ready);
	modport sink (input valid, input pixel_out, input was_replaced, input last_of_frame,
		output ready);
endinterface
`default_nettype wire

[rtl/ornf_line_mem.sv]
`default_nettype none
module ornf_line_mem #(
	parameter int DEPTH = 1024,
	parameter int DW    = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [1:0]               wslot,
	input  wire logic [$clog2(DEPTH)-1:0] wcol,
	input  wire logic [DW-1:0]            wdata,
	input  wire logic [1:0]               rslot,
	input  wire logic [$clog2(DEPTH)-1:0] rcol,
	output logic      [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [0:2][0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wslot][wcol] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[rslot][rcol];
	end

endmodule
`default_nettype wire

[rtl/ornf_div.sv]
`default_nettype none
module ornf_div #(
	parameter int W = 36
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [W-1:0] dividend,
	input  wire logic [3:0]          divisor,
	output logic                     done,
	output logic signed [W-1:0]      quotient
);

	localparam int CNTW = $clog2(W + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [3:0]      rem_q;
	logic [W-1:0]    quo_q;
	logic [3:0]      dvs_q;
	logic            neg_q;
	logic [4:0]      trial;
	logic            ge;
	logic [4:0]      diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1];
			quo_q <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[3:0] : trial[3:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign quotient = neg_q ? $signed(~quo_q + W'(1)) : $signed(quo_q);

endmodule
`default_nettype wire

[rtl/out_of_range_pixel_neighbor_fill.sv]
`default_nettype none
// Replaces height samples outside [low_limit, high_limit] by the truncated mean of their
// in-range 3x3 neighbors (raised to at least low_limit), in place, over a raster stream.
// Results lag input by one row plus one pixel; flush items drain the frame tail. A sample
// that produces no result is stored on acceptance. A flush that produces a result passes
// through acceptance, reading of the nine taps from the three-row line memory (one read per
// cycle), decision, and output load with write-back of a replaced value; a sample that
// produces a result then stores itself in a further state. A replaced sample whose
// neighbors include valid ones also passes through the bit-serial mean divider, and the
// output load waits while the output register is full and not being taken.
// Frame size writes restart the frame and drop pending results.
module out_of_range_pixel_neighbor_fill
	import ornf_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 4096,
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ornf_in_if.sink       samples,
	ornf_out_if.source    results,
	input  wire logic     cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [((SAMPLE_BITS > FH_BITS) ? SAMPLE_BITS : FH_BITS)-1:0] cfg_data
);

	localparam int SB   = SAMPLE_BITS;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + 1);
	localparam int PW   = $clog2(MAX_WIDTH + 2);
	localparam int SUMW = SB + 4;

	st_t state_q, state_d;

	logic [FW_BITS-1:0]   fw_q;
	logic [FH_BITS-1:0]   fh_q;
	logic signed [SB-1:0] low_q, high_q;
	logic [WW-1:0]        eff_w;
	logic [RW-1:0]        eff_h;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [1:0]    in_slot_q, out_slot_q;
	logic [PW-1:0] pend_q;

	logic                 has_in_q;
	logic signed [SB-1:0] in_val_q;
	logic [3:0]           k_q;
	logic [3:0]           k_s1;
	logic                 vld_s1, ok_s1, use_in_s1;
	logic signed [SB-1:0] orig_q;
	logic signed [SUMW-1:0] sum_q;
	logic [3:0]           cnt_q;
	logic signed [SB-1:0] res_q;
	logic                 rep_q;

	logic                 ov_q, orep_q, olast_q;
	logic signed [SB-1:0] opix_q;

	logic accept, is_pix, emit_pix, emit_flush, out_free;
	logic mem_we;
	logic [1:0] mem_wslot, mem_rslot;
	logic [CW-1:0] mem_wcol, mem_rcol;
	logic [SB-1:0] mem_wdata, mem_rdata;
	logic div_start, div_done;
	logic signed [SUMW-1:0] div_q;

	logic up_ok, down_ok, left_ok, right_ok;
	logic [1:0] up_slot, down_slot;
	logic [PW-1:0] d_tap;
	logic tap_geo, tap_ord, tap_ok, tap_use_in;
	logic [1:0] tap_slot;
	logic [CW-1:0] tap_col;
	logic signed [SB-1:0] tap_val;
	logic tap_in_range, orig_in_range;
	logic out_wrap, out_frame_end, in_wrap;

	always_comb begin
		if (fw_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(fw_q);
		end
		if (fh_q == '0) begin
			eff_h = RW'(1);
		end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
			eff_h = RW'(MAX_HEIGHT);
		end else begin
			eff_h = RW'(fh_q);
		end
	end

	assign accept     = samples.valid && samples.ready;
	assign is_pix     = (samples.req_type == REQ_PIXEL) && (in_row_q < eff_h);
	assign emit_pix   = is_pix && (pend_q == PW'(eff_w) + PW'(1));
	assign emit_flush = !is_pix && (pend_q != '0);
	assign out_free   = !ov_q || results.ready;

	assign up_ok     = out_row_q != '0;
	assign down_ok   = (out_row_q + RW'(1)) < eff_h;
	assign left_ok   = out_col_q != '0;
	assign right_ok  = (WW'(out_col_q) + WW'(1)) < eff_w;
	assign up_slot   = (out_slot_q == 2'd0) ? 2'd2 : out_slot_q - 2'd1;
	assign down_slot = (out_slot_q == 2'd2) ? 2'd0 : out_slot_q + 2'd1;

	assign out_wrap      = (WW'(out_col_q) + WW'(1)) >= eff_w;
	assign out_frame_end = out_wrap && ((out_row_q + RW'(1)) >= eff_h);
	assign in_wrap       = (WW'(in_col_q) + WW'(1)) >= eff_w;

	always_comb begin
		tap_geo  = 1'b0;
		tap_slot = out_slot_q;
		tap_col  = out_col_q;
		d_tap    = '0;
		tap_ord  = 1'b1;
		case (k_q)
			TAP_CENTER: tap_geo = 1'b1;
			TAP_UL: begin
				tap_geo = up_ok && left_ok;
				tap_slot = up_slot;
			end
			TAP_U: begin
				tap_geo = up_ok;
				tap_slot = up_slot;
			end
			TAP_UR: begin
				tap_geo = up_ok && right_ok;
				tap_slot = up_slot;
			end
			TAP_L: tap_geo = left_ok;
			TAP_R: begin
				tap_geo = right_ok;
				d_tap = PW'(1);
				tap_ord = 1'b0;
			end
			TAP_DL: begin
				tap_geo = down_ok && left_ok;
				tap_slot = down_slot;
				d_tap = PW'(eff_w) - PW'(1);
				tap_ord = 1'b0;
			end
			TAP_D: begin
				tap_geo = down_ok;
				tap_slot = down_slot;
				d_tap = PW'(eff_w);
				tap_ord = 1'b0;
			end
			TAP_DR: begin
				tap_geo = down_ok && right_ok;
				tap_slot = down_slot;
				d_tap = PW'(eff_w) + PW'(1);
				tap_ord = 1'b0;
			end
			default: tap_geo = 1'b0;
		endcase
		if (tap_geo && (k_q == TAP_UL || k_q == TAP_L || k_q == TAP_DL)) begin
			tap_col = out_col_q - CW'(1);
		end else if (tap_geo && (k_q == TAP_UR || k_q == TAP_R || k_q == TAP_DR)) begin
			tap_col = out_col_q + CW'(1);
		end
		tap_use_in = !tap_ord && has_in_q && (d_tap == pend_q);
		tap_ok     = tap_geo && (tap_ord || (d_tap < pend_q) || tap_use_in);
	end

	assign tap_val       = use_in_s1 ? in_val_q : $signed(mem_rdata);
	assign tap_in_range  = !(tap_val < low_q || tap_val > high_q);
	assign orig_in_range = !(orig_q < low_q || orig_q > high_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (emit_pix || emit_flush)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (k_q == TAP_END) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!orig_in_range && cnt_q != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = has_in_q ? ST_WPIX : ST_IDLE;
				end
			end
			ST_WPIX: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = state_q == ST_IDLE;
		div_start     = (state_q == ST_DECIDE) && !orig_in_range && (cnt_q != '0);
		mem_we        = 1'b0;
		mem_wslot     = in_slot_q;
		mem_wcol      = in_col_q;
		mem_wdata     = samples.pixel_value;
		case (state_q)
			ST_IDLE: mem_we = accept && is_pix && !emit_pix;
			ST_OUT: begin
				mem_we    = out_free && rep_q;
				mem_wslot = out_slot_q;
				mem_wcol  = out_col_q;
				mem_wdata = res_q;
			end
			ST_WPIX: begin
				mem_we    = 1'b1;
				mem_wdata = in_val_q;
			end
			default: mem_we = 1'b0;
		endcase
		mem_rslot = tap_slot;
		mem_rcol  = tap_col;
	end

	ornf_line_mem #(.DEPTH(MAX_WIDTH), .DW(SB)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.wslot (mem_wslot),
		.wcol  (mem_wcol),
		.wdata (mem_wdata),
		.rslot (mem_rslot),
		.rcol  (mem_rcol),
		.rdata (mem_rdata)
	);

	ornf_div #(.W(SUMW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fw_q       <= FW_RESET;
			fh_q       <= FH_RESET;
			low_q      <= {1'b1, {(SB-1){1'b0}}};
			high_q     <= {1'b0, {(SB-1){1'b1}}};
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
			ov_q       <= 1'b0;
			vld_s1     <= 1'b0;
			k_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
			vld_s1 <= (state_q == ST_READ) && (k_q != TAP_END);
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH: fw_q <= cfg_data[FW_BITS-1:0];
					CFG_HEIGHT: fh_q <= cfg_data[FH_BITS-1:0];
					CFG_LOW: low_q <= $signed(cfg_data[SB-1:0]);
					CFG_HIGH: high_q <= $signed(cfg_data[SB-1:0]);
					default: low_q <= low_q;
				endcase
				if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
					pend_q     <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept && is_pix && !emit_pix) begin
						pend_q <= pend_q + PW'(1);
						if (in_wrap) begin
							in_col_q  <= '0;
							in_row_q  <= in_row_q + RW'(1);
							in_slot_q <= (in_slot_q == 2'd2) ? 2'd0 : in_slot_q + 2'd1;
						end else begin
							in_col_q <= in_col_q + CW'(1);
						end
					end
				end
				ST_READ: begin
					if (k_q != TAP_END) begin
						k_q <= k_q + 4'd1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						if (out_frame_end) begin
							in_col_q   <= '0;
							in_row_q   <= '0;
							in_slot_q  <= '0;
							out_col_q  <= '0;
							out_row_q  <= '0;
							out_slot_q <= '0;
							pend_q     <= '0;
						end else if (out_wrap) begin
							pend_q     <= pend_q - PW'(1);
							out_col_q  <= '0;
							out_row_q  <= out_row_q + RW'(1);
							out_slot_q <= down_slot;
						end else begin
							pend_q    <= pend_q - PW'(1);
							out_col_q <= out_col_q + CW'(1);
						end
					end
				end
				ST_WPIX: begin
					pend_q <= pend_q + PW'(1);
					if (in_wrap) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + RW'(1);
						in_slot_q <= (in_slot_q == 2'd2) ? 2'd0 : in_slot_q + 2'd1;
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		k_s1      <= k_q;
		ok_s1     <= tap_ok;
		use_in_s1 <= tap_use_in;
		if (state_q == ST_IDLE && accept) begin
			has_in_q <= is_pix;
			in_val_q <= samples.pixel_value;
			sum_q    <= '0;
			cnt_q    <= '0;
		end
		if (vld_s1) begin
			if (k_s1 == TAP_CENTER) begin
				orig_q <= $signed(mem_rdata);
			end else if (ok_s1 && tap_in_range) begin
				sum_q <= sum_q + SUMW'(tap_val);
				cnt_q <= cnt_q + 4'd1;
			end
		end
		if (state_q == ST_DECIDE) begin
			rep_q <= !orig_in_range;
			res_q <= orig_in_range ? orig_q : low_q;
		end
		if (state_q == ST_DIV && div_done) begin
			res_q <= (div_q > SUMW'(low_q)) ? div_q[SB-1:0] : low_q;
		end
		if (state_q == ST_OUT && out_free) begin
			opix_q  <= res_q;
			orep_q  <= rep_q;
			olast_q <= (out_row_q == eff_h - RW'(1)) && (WW'(out_col_q) == eff_w - WW'(1));
		end
	end

	assign results.valid         = ov_q;
	assign results.pixel_out     = opix_q;
	assign results.was_replaced  = orep_q;
	assign results.last_of_frame = olast_q;

endmodule
`default_nettype wire
